/* hw/rtl/adsr_pkg.sv */
// Shared types and constants of the ADSR envelope VCA.
// Holds the request and result structs, request and register codes, queue depths.
// No dependencies; every other file imports this package.
package adsr_pkg;

    localparam int SAMPLE_W            = 16;
    localparam int REG_W               = 16;
    localparam int LEVEL_OUT_W         = 16;
    localparam int PHASE_W             = 3;
    localparam int CFG_IDX_W           = 3;
    localparam int LEVEL_FRAC_BITS_DEF = 15;
    localparam int CMD_DEPTH           = 2;
    localparam int OUT_DEPTH           = 4;

    // Request type codes on the input channel.
    localparam logic [1:0] REQ_SAMPLE   = 2'd0;
    localparam logic [1:0] REQ_NOTE_ON  = 2'd1;
    localparam logic [1:0] REQ_NOTE_OFF = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_LEVEL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LEVEL   = 3'd4;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic signed [SAMPLE_W-1:0] sample_in;
    } req_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic [LEVEL_OUT_W-1:0]     envelope_level;
        logic [PHASE_W-1:0]         phase;
    } res_item_t;

    typedef enum logic [1:0] {
        CMD_SAMPLE   = 2'd0,
        CMD_NOTE_ON  = 2'd1,
        CMD_NOTE_OFF = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                  kind;
        logic signed [SAMPLE_W-1:0] sample;
    } cmd_t;

endpackage

/* hw/rtl/adsr_envelope_vca.sv */
// ADSR envelope VCA. Requests (audio sample, note on, note off) are pushed into a two-entry
// command queue; the envelope stage pops one command per cycle while the result buffer grants
// credit, so the block then sustains one request per clock. A sample's result passes the
// envelope update, multiply, floor and saturate into a four-entry buffer on the result port;
// note events and unknown request types give no result. The queue fills, and full rises, only
// when the result buffer backs up. Configuration writes are always ready and take effect
// for requests that reach the envelope stage afterwards; write them while the block is idle.
// Depends on adsr_pkg, adsr_front, adsr_env and adsr_vca.
module adsr_envelope_vca
    import adsr_pkg::*;
#(
    parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  req_item_t            request,
    output logic                 empty,
    input  logic                 pop,
    output res_item_t            result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data
);

    localparam int LW = LEVEL_FRAC_BITS + 1;
    localparam int TW = (LW > REG_W) ? LW : REG_W;

    logic                       cmd_valid, cmd_pop, credit_ok;
    cmd_t                       cmd_head;
    logic                       s1_valid;
    logic signed [SAMPLE_W-1:0] s1_sample;
    logic [TW-1:0]              s1_level;
    logic [PHASE_W-1:0]         s1_phase;

    assign cfg_ready = 1'b1;

    adsr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .cmd_valid (cmd_valid),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop)
    );

    adsr_env #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_env (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop),
        .credit_ok (credit_ok),
        .s1_valid  (s1_valid),
        .s1_sample (s1_sample),
        .s1_level  (s1_level),
        .s1_phase  (s1_phase)
    );

    adsr_vca #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_vca (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_sample (s1_sample),
        .s1_level  (s1_level),
        .s1_phase  (s1_phase),
        .credit_ok (credit_ok),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

/* hw/rtl/adsr_front.sv */
// Front end of the ADSR envelope VCA: classifies requests and queues commands.
// Depends on adsr_pkg; feeds adsr_env through a short command queue.
module adsr_front
    import adsr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  req_item_t request,
    output logic      cmd_valid,
    output cmd_t      cmd_head,
    input  logic      cmd_pop
);

    localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    cmd_t             mem [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    cmd_t             cmd_in;
    logic             keep;
    logic             wr, rd;

    // Unknown request types are taken and dropped without touching any state.
    always_comb
    begin
        cmd_in.kind   = CMD_SAMPLE;
        cmd_in.sample = request.sample_in;
        keep          = 1'b0;
        unique case (request.req_type)
            REQ_SAMPLE:
            begin
                cmd_in.kind = CMD_SAMPLE;
                keep        = 1'b1;
            end
            REQ_NOTE_ON:
            begin
                cmd_in.kind = CMD_NOTE_ON;
                keep        = 1'b1;
            end
            REQ_NOTE_OFF:
            begin
                cmd_in.kind = CMD_NOTE_OFF;
                keep        = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign full      = (count_reg == CNT_W'(CMD_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd_head  = mem[rd_ptr_reg];
    assign wr        = push && !full && keep;
    assign rd        = cmd_pop && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr && !rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd && !wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_cmd_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CMD_DEPTH))
        else $error("command queue count beyond its depth");

    a_cmd_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (rd && !wr) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("command queue count did not drop on a lone pop");

endmodule

/* hw/rtl/adsr_env.sv */
// Back end of the ADSR envelope VCA: configuration registers, phase machine and slew limiter.
// Depends on adsr_pkg; pops commands from adsr_front and hands samples to adsr_vca.
module adsr_env
    import adsr_pkg::*;
#(
    parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF,
    localparam int LW = LEVEL_FRAC_BITS + 1,
    localparam int TW = (LW > REG_W) ? LW : REG_W
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [REG_W-1:0]           cfg_data,
    input  logic                       cmd_valid,
    input  cmd_t                       cmd_head,
    output logic                       cmd_pop,
    input  logic                       credit_ok,
    output logic                       s1_valid,
    output logic signed [SAMPLE_W-1:0] s1_sample,
    output logic [TW-1:0]              s1_level,
    output logic [PHASE_W-1:0]         s1_phase
);

    localparam int CW        = TW + 2;
    localparam int LEVEL_MAX = (1 << LW) - 1;
    localparam int SLEW_STEP = ((1 << LEVEL_FRAC_BITS) + 50) / 100;
    localparam logic signed [CW-1:0] LMAX_C = CW'(LEVEL_MAX);
    localparam logic signed [CW-1:0] SLEW_C = CW'(SLEW_STEP);

    localparam logic [PHASE_W-1:0] PHASE_IDLE    = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_ATTACK  = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_DECAY   = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_SUSTAIN = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_RELEASE = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_ATTACK  = 5'b00010,
        ST_DECAY   = 5'b00100,
        ST_SUSTAIN = 5'b01000,
        ST_RELEASE = 5'b10000
    } env_state_t;

    function automatic logic [PHASE_W-1:0] phase_code(input env_state_t st);
        logic [PHASE_W-1:0] code;
        begin
            code = PHASE_IDLE;
            unique case (st)
                ST_IDLE:    code = PHASE_IDLE;
                ST_ATTACK:  code = PHASE_ATTACK;
                ST_DECAY:   code = PHASE_DECAY;
                ST_SUSTAIN: code = PHASE_SUSTAIN;
                ST_RELEASE: code = PHASE_RELEASE;
                default:    code = PHASE_IDLE;
            endcase
            return code;
        end
    endfunction

    logic [REG_W-1:0] attack_reg, decay_reg, release_reg, peak_reg, hold_reg;
    env_state_t       state_reg, state_next, state_upd;
    logic [TW-1:0]    tgt_reg, cur_reg, tgt_upd, cur_upd;
    logic             s1_valid_reg, s1_upd;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic [TW-1:0]              s1_level_reg;
    logic [PHASE_W-1:0]         s1_phase_reg;

    logic signed [CW-1:0] tgt_x, cur_x, atk_x, dec_x, rel_x, peak_x, hold_x;
    logic signed [CW-1:0] t_adv, diff, cur_slew;

    assign tgt_x  = CW'(tgt_reg);
    assign cur_x  = CW'(cur_reg);
    assign atk_x  = CW'(attack_reg);
    assign dec_x  = CW'(decay_reg);
    assign rel_x  = CW'(release_reg);
    assign peak_x = CW'(peak_reg);
    assign hold_x = CW'(hold_reg);

    assign cmd_pop = cmd_valid && credit_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= REG_W'(1);
            decay_reg   <= REG_W'(1);
            release_reg <= REG_W'(1);
            peak_reg    <= REG_W'(32768);
            hold_reg    <= REG_W'(32768);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ATTACK_STEP:  attack_reg  <= cfg_data;
                CFG_DECAY_STEP:   decay_reg   <= cfg_data;
                CFG_RELEASE_STEP: release_reg <= cfg_data;
                CFG_PEAK_LEVEL:   peak_reg    <= cfg_data;
                CFG_HOLD_LEVEL:   hold_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Target update for one sample; the new phase comes out with it.
    always_comb
    begin
        t_adv      = tgt_x;
        state_next = state_reg;
        unique case (state_reg)
            ST_ATTACK:
            begin
                t_adv = tgt_x + atk_x;
                if (t_adv > LMAX_C)
                begin
                    t_adv = LMAX_C;
                end
                if (t_adv >= peak_x)
                begin
                    state_next = ST_DECAY;
                end
            end
            ST_DECAY:
            begin
                t_adv = tgt_x - dec_x;
                if (t_adv < 0)
                begin
                    t_adv = '0;
                end
                if (t_adv <= hold_x)
                begin
                    state_next = ST_SUSTAIN;
                end
            end
            ST_SUSTAIN:
            begin
                t_adv = hold_x;
            end
            ST_RELEASE:
            begin
                t_adv = tgt_x - rel_x;
                if (t_adv <= 0)
                begin
                    t_adv      = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                t_adv = tgt_x;
            end
        endcase
    end

    // The level follows the new target by at most one slew step per sample.
    always_comb
    begin
        diff = cur_x - t_adv;
        if (diff > SLEW_C)
        begin
            cur_slew = cur_x - SLEW_C;
        end
        else if (diff < -SLEW_C)
        begin
            cur_slew = cur_x + SLEW_C;
        end
        else
        begin
            cur_slew = t_adv;
        end
    end

    always_comb
    begin
        state_upd = state_reg;
        if (cmd_pop)
        begin
            case (cmd_head.kind)
                CMD_SAMPLE:  state_upd = state_next;
                CMD_NOTE_ON: state_upd = ST_ATTACK;
                CMD_NOTE_OFF: state_upd = ST_RELEASE;
                default:     state_upd = state_reg;
            endcase
        end
    end

    always_comb
    begin
        tgt_upd = tgt_reg;
        cur_upd = cur_reg;
        s1_upd  = 1'b0;
        if (cmd_pop)
        begin
            case (cmd_head.kind)
                CMD_SAMPLE:
                begin
                    tgt_upd = t_adv[TW-1:0];
                    cur_upd = cur_slew[TW-1:0];
                    s1_upd  = 1'b1;
                end
                CMD_NOTE_OFF:
                begin
                    if (tgt_x > hold_x)
                    begin
                        tgt_upd = TW'(hold_reg);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tgt_reg      <= '0;
            cur_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_upd;
            tgt_reg      <= tgt_upd;
            cur_reg      <= cur_upd;
            s1_valid_reg <= s1_upd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_upd)
        begin
            s1_sample_reg <= cmd_head.sample;
            s1_level_reg  <= cur_upd;
            s1_phase_reg  <= phase_code(state_upd);
        end
    end

    assign s1_valid  = s1_valid_reg;
    assign s1_sample = s1_sample_reg;
    assign s1_level  = s1_level_reg;
    assign s1_phase  = s1_phase_reg;

    a_note_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && cmd_head.kind != CMD_SAMPLE) |=> !s1_valid_reg)
        else $error("note event produced a sample record");

    a_record_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $past(cmd_pop))
        else $error("sample record without a command pop");

endmodule

/* hw/rtl/adsr_vca.sv */
// Output side of the ADSR envelope VCA: sample times level, floor and saturate, result buffer.
// Depends on adsr_pkg; takes sample records from adsr_env and grants it credit.
module adsr_vca
    import adsr_pkg::*;
#(
    parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF,
    localparam int LW = LEVEL_FRAC_BITS + 1,
    localparam int TW = (LW > REG_W) ? LW : REG_W
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s1_valid,
    input  logic signed [SAMPLE_W-1:0] s1_sample,
    input  logic [TW-1:0]              s1_level,
    input  logic [PHASE_W-1:0]         s1_phase,
    output logic                       credit_ok,
    output logic                       empty,
    input  logic                       pop,
    output res_item_t                  result
);

    localparam int PW    = SAMPLE_W + TW + 1;
    localparam int PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int CNT_W = $clog2(OUT_DEPTH + 3);
    localparam logic signed [PW-1:0] Q_MAX = PW'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [PW-1:0] Q_MIN = -Q_MAX - 1;

    logic signed [SAMPLE_W-1:0] smp_x;
    logic signed [TW:0]         lvl_x;
    logic signed [PW-1:0]       prod;
    logic signed [PW-1:0]       prod_reg;
    logic [LEVEL_OUT_W-1:0]     lvl2_reg;
    logic [PHASE_W-1:0]         ph2_reg;
    logic                       v2_reg;
    logic signed [PW-1:0]       q;
    res_item_t                  res_in;

    res_item_t        mem [OUT_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             wr, rd;

    assign smp_x = s1_sample;
    assign lvl_x = {1'b0, s1_level};
    assign prod  = smp_x * lvl_x;

    always_ff @(posedge clk)
    begin
        if (s1_valid)
        begin
            prod_reg <= prod;
            lvl2_reg <= s1_level[LEVEL_OUT_W-1:0];
            ph2_reg  <= s1_phase;
        end
    end

    // An arithmetic shift rounds toward minus infinity for both signs.
    always_comb
    begin
        q = prod_reg >>> LEVEL_FRAC_BITS;
        if (q > Q_MAX)
        begin
            q = Q_MAX;
        end
        else if (q < Q_MIN)
        begin
            q = Q_MIN;
        end
        res_in.sample_out     = q[SAMPLE_W-1:0];
        res_in.envelope_level = lvl2_reg;
        res_in.phase          = ph2_reg;
    end

    // Every record in flight already owns a buffer slot, so the pipeline never stalls.
    assign credit_ok = (count_reg + CNT_W'(s1_valid) + CNT_W'(v2_reg)) < CNT_W'(OUT_DEPTH);
    assign wr        = v2_reg;
    assign empty     = (count_reg == '0);
    assign rd        = pop && !empty;
    assign result    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wr_ptr_reg] <= res_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg     <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            v2_reg <= s1_valid;
            if (wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr && !rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd && !wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr |-> (count_reg != CNT_W'(OUT_DEPTH)))
        else $error("result buffer written while full");

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg + CNT_W'(s1_valid) + CNT_W'(v2_reg)) <= CNT_W'(OUT_DEPTH))
        else $error("more results in flight than buffer slots");

endmodule

/* verif/adsr_envelope_vca_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for adsr_envelope_vca: a predictor of the envelope phases, slew and
// scaled output checks every result popped from the block under random idling and stalls.
// Depends on adsr_pkg and the adsr_envelope_vca RTL.

import adsr_pkg::*;

typedef enum logic [PHASE_W-1:0] {
    ENV_IDLE    = 3'd0,
    ENV_ATTACK  = 3'd1,
    ENV_DECAY   = 3'd2,
    ENV_SUSTAIN = 3'd3,
    ENV_RELEASE = 3'd4
} env_phase_t;

localparam logic [1:0] REQ_UNKNOWN = 2'd3;
localparam longint LEVEL_TOP = (longint'(1) << (LEVEL_FRAC_BITS_DEF + 1)) - 1;
localparam longint SLEW_LIMIT = ((longint'(1) << LEVEL_FRAC_BITS_DEF) + 50) / 100;
localparam longint AUDIO_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
localparam longint AUDIO_MIN = -(longint'(1) << (SAMPLE_W - 1));

class vca_scoreboard;
    longint attack_step;
    longint decay_step;
    longint release_step;
    longint peak_level;
    longint hold_level;
    env_phase_t env_phase;
    longint target_level;
    longint current_level;
    res_item_t predicted_outputs[$];
    int mismatches;

    function new();
        attack_step   = 1;
        decay_step    = 1;
        release_step  = 1;
        peak_level    = 32768;
        hold_level    = 32768;
        env_phase     = ENV_IDLE;
        target_level  = 0;
        current_level = 0;
        mismatches    = 0;
    endfunction

    function void store_register(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
        case (idx)
            CFG_ATTACK_STEP:  attack_step  = longint'(value);
            CFG_DECAY_STEP:   decay_step   = longint'(value);
            CFG_RELEASE_STEP: release_step = longint'(value);
            CFG_PEAK_LEVEL:   peak_level   = longint'(value);
            CFG_HOLD_LEVEL:   hold_level   = longint'(value);
            default: ;
        endcase
    endfunction

    // Updates the envelope for one accepted request and queues the output a sample makes.
    function void take_request(req_item_t req);
        longint audio;
        longint product;
        longint scaled;
        res_item_t out_item;
        audio = longint'($signed(req.sample_in));
        case (req.req_type)
            REQ_NOTE_ON:
                env_phase = ENV_ATTACK;
            REQ_NOTE_OFF:
            begin
                env_phase = ENV_RELEASE;
                if (target_level > hold_level)
                    target_level = hold_level;
            end
            REQ_SAMPLE:
            begin
                case (env_phase)
                    ENV_ATTACK:
                    begin
                        target_level = target_level + attack_step;
                        if (target_level > LEVEL_TOP)
                            target_level = LEVEL_TOP;
                        if (target_level >= peak_level)
                            env_phase = ENV_DECAY;
                    end
                    ENV_DECAY:
                    begin
                        target_level = target_level - decay_step;
                        if (target_level < 0)
                            target_level = 0;
                        if (target_level <= hold_level)
                            env_phase = ENV_SUSTAIN;
                    end
                    ENV_SUSTAIN:
                        target_level = hold_level;
                    ENV_RELEASE:
                    begin
                        target_level = target_level - release_step;
                        if (target_level <= 0)
                        begin
                            target_level = 0;
                            env_phase = ENV_IDLE;
                        end
                    end
                    default: ;
                endcase
                if (current_level - target_level > SLEW_LIMIT)
                    current_level = current_level - SLEW_LIMIT;
                else if (current_level - target_level < -SLEW_LIMIT)
                    current_level = current_level + SLEW_LIMIT;
                else
                    current_level = target_level;
                // An arithmetic shift of the signed product rounds toward minus infinity.
                product = audio * current_level;
                scaled = product >>> LEVEL_FRAC_BITS_DEF;
                if (scaled > AUDIO_MAX)
                    scaled = AUDIO_MAX;
                if (scaled < AUDIO_MIN)
                    scaled = AUDIO_MIN;
                out_item.sample_out     = scaled[SAMPLE_W-1:0];
                out_item.envelope_level = current_level[LEVEL_OUT_W-1:0];
                out_item.phase          = env_phase;
                predicted_outputs.push_back(out_item);
            end
            default: ;
        endcase
    endfunction

    function void check_result(res_item_t got);
        res_item_t want;
        if (predicted_outputs.size() == 0)
        begin
            $display("%0t: result with no request waiting: sample_out %0d level %0d phase %0d",
                     $time, got.sample_out, got.envelope_level, got.phase);
            mismatches++;
            return;
        end
        want = predicted_outputs.pop_front();
        if (got.sample_out !== want.sample_out)
        begin
            $display("%0t: sample_out expected %0d, actual %0d",
                     $time, want.sample_out, got.sample_out);
            mismatches++;
        end
        if (got.envelope_level !== want.envelope_level)
        begin
            $display("%0t: envelope_level expected %0d, actual %0d",
                     $time, want.envelope_level, got.envelope_level);
            mismatches++;
        end
        if (got.phase !== want.phase)
        begin
            $display("%0t: phase expected %0d, actual %0d", $time, want.phase, got.phase);
            mismatches++;
        end
    endfunction

    function int pending();
        return predicted_outputs.size();
    endfunction
endclass

module adsr_envelope_vca_test;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int LONG_HOLD       = 300;
    localparam int PHASE_COUNT     = 12;
    localparam int ITEMS_PER_PHASE = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    req_item_t request = '0;
    logic empty;
    logic pop = 1'b0;
    res_item_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0] cfg_data = '0;

    vca_scoreboard sb;
    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    int requests_sent = 0;
    int hold_seq = 0;
    int seen_seq = 0;
    int hold_left = 0;
    int cycle_count = 0;

    adsr_envelope_vca uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.store_register(cfg_index, cfg_data);
            if (push && !full)
                sb.take_request(request);
            if (pop && !empty)
                sb.check_result(result);
        end
    end

    // Result side: a long hold-off starts whenever the stimulus bumps hold_seq.
    always @(posedge clk)
    begin
        if (hold_seq != seen_seq)
        begin
            seen_seq <= hold_seq;
            hold_left <= LONG_HOLD;
            pop <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    function automatic logic [SAMPLE_W-1:0] pick_audio();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [REG_W-1:0] pick_step();
        case ($urandom_range(7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'd32768;
            3: return 16'd1;
            default: return REG_W'($urandom_range(200, 8000));
        endcase
    endfunction

    function automatic logic [REG_W-1:0] pick_level();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'hFFFF;
            default: return REG_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic int pick_length();
        if ($urandom_range(9) == 0)
            return $urandom_range(60, 250);
        return $urandom_range(2, 30);
    endfunction

    task automatic send_request(input logic [1:0] kind, input logic [SAMPLE_W-1:0] value);
        req_item_t item;
        item.req_type = kind;
        item.sample_in = value;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        request <= item;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (kind != REQ_UNKNOWN)
            requests_sent++;
    endtask

    // Stops sending, waits for every outstanding result, then lets trailing note events drain.
    task automatic settle_block();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic apply_config(input logic [REG_W-1:0] attack, input logic [REG_W-1:0] decay,
                                input logic [REG_W-1:0] release_rate,
                                input logic [REG_W-1:0] peak, input logic [REG_W-1:0] hold);
        write_register(CFG_ATTACK_STEP, attack);
        write_register(CFG_DECAY_STEP, decay);
        write_register(CFG_RELEASE_STEP, release_rate);
        write_register(CFG_PEAK_LEVEL, peak);
        write_register(CFG_HOLD_LEVEL, hold);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        // Reset settings: idle output, a stray request code, release from idle, slow attack.
        send_request(REQ_SAMPLE, 16'h7FFF);
        send_request(REQ_UNKNOWN, 16'hFFFF);
        send_request(REQ_NOTE_OFF, 16'h0000);
        send_request(REQ_SAMPLE, 16'h8000);
        send_request(REQ_NOTE_ON, 16'h0000);
        send_request(REQ_SAMPLE, 16'h7FFF);
        send_request(REQ_SAMPLE, 16'h8000);
        send_request(REQ_SAMPLE, 16'hFFFF);
        send_request(REQ_SAMPLE, 16'h0001);
        send_request(REQ_SAMPLE, 16'h0000);
        settle_block();
        // Attack overshoots the peak, decay underflows to zero, release ends in one step.
        apply_config(16'd32768, 16'd20000, 16'hFFFF, 16'd20000, 16'd8000);
        send_request(REQ_NOTE_ON, 16'h0000);
        repeat (4) send_request(REQ_SAMPLE, 16'h7FFF);
        send_request(REQ_NOTE_OFF, 16'h0000);
        send_request(REQ_SAMPLE, 16'h8000);
        send_request(REQ_SAMPLE, 16'h7FFF);
        settle_block();
    endtask

    // Loud envelope with the result side held off long enough for full to rise.
    task automatic fill_and_stall();
        send_idle_pct = 0;
        pop_stall_pct = 0;
        apply_config(16'hFFFF, 16'd0, 16'd300, 16'hFFFF, 16'hFFFF);
        hold_seq <= hold_seq + 1;
        send_request(REQ_NOTE_ON, 16'h0000);
        repeat (220) send_request(REQ_SAMPLE, pick_audio());
        send_request(REQ_NOTE_OFF, 16'h0000);
        repeat (10) send_request(REQ_SAMPLE, pick_audio());
        settle_block();
    endtask

    // Segments are cut short once the goal is reached so each phase stays near its count.
    task automatic run_phase(input int goal);
        int seg;
        while (requests_sent < goal)
        begin
            if ($urandom_range(99) < 80)
            begin
                send_request(REQ_NOTE_ON, pick_audio());
                seg = pick_length();
                repeat (seg)
                    if (requests_sent < goal)
                        send_request(REQ_SAMPLE, pick_audio());
                send_request(REQ_NOTE_OFF, pick_audio());
                seg = pick_length();
                repeat (seg)
                    if (requests_sent < goal)
                        send_request(REQ_SAMPLE, pick_audio());
            end
            else
            begin
                seg = $urandom_range(1, 6);
                repeat (seg)
                    if (requests_sent < goal)
                        send_request(2'($urandom_range(3)), pick_audio());
            end
        end
    endtask

    initial
    begin
        int ph;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        fill_and_stall();
        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            settle_block();
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    pop_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 86;
                    pop_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    pop_stall_pct = 86;
                end
                default:
                begin
                    send_idle_pct = 17;
                    pop_stall_pct = 17;
                end
            endcase
            case (ph)
                0: apply_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                1: apply_config(16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd32768);
                default: apply_config(pick_step(), pick_step(), pick_step(),
                                      pick_level(), pick_level());
            endcase
            run_phase(requests_sent + ITEMS_PER_PHASE);
        end
        settle_block();
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/adsr_pkg.sv
hw/rtl/adsr_front.sv
hw/rtl/adsr_env.sv
hw/rtl/adsr_vca.sv
hw/rtl/adsr_envelope_vca.sv
verif/adsr_envelope_vca_test.sv
